// ----- hw/rtl/qpt_pkg.sv -----
`timescale 1ns / 1ps
// Package: widths, stage counts, lane type and helpers for the pose-to-transform pipeline.
package qpt_pkg;

    localparam int QUAT_W  = 16;
    localparam int POS_W   = 32;
    localparam int ROT_W   = 18;
    localparam int PROD_W  = 32;
    localparam int NORM_W  = 33;
    localparam int SUM_W   = 33;
    localparam int MAG_W   = 32;
    localparam int FRAC_SH = 17;
    localparam int DVD_W   = MAG_W + FRAC_SH;
    localparam int QUOT_W  = 18;
    localparam int REM_W   = NORM_W;
    localparam int VAL_W   = QUOT_W + 1;
    localparam int LANES   = 9;
    localparam int NPROD   = 10;
    localparam int NSTG    = QUOT_W + 4;

    localparam int IN_W    = 4 * QUAT_W + 3 * POS_W;
    localparam int OUT_RAW = LANES * ROT_W + 3 * POS_W;
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

    localparam logic [LANES-1:0] DIAG_MASK = 9'b1_0001_0001;

    localparam logic signed [VAL_W-1:0] ROT_ONE = 19'sd65536;

    localparam int PR_XX = 0;
    localparam int PR_YY = 1;
    localparam int PR_ZZ = 2;
    localparam int PR_WW = 3;
    localparam int PR_XY = 4;
    localparam int PR_XZ = 5;
    localparam int PR_YZ = 6;
    localparam int PR_XW = 7;
    localparam int PR_YW = 8;
    localparam int PR_ZW = 9;

    typedef struct packed {
        logic              neg;
        logic [REM_W-1:0]  rem;
        logic [QUOT_W-1:0] lq;   // low dividend bits shift out, quotient bits shift in
    } lane_t;

    function automatic logic [ROT_W-1:0] sat_rot(input logic signed [VAL_W-1:0] v);
        logic signed [VAL_W-1:0] r;
        begin
            r = v;
            if (v > ROT_ONE)
            begin
                r = ROT_ONE;
            end
            else if (v < -ROT_ONE)
            begin
                r = -ROT_ONE;
            end
            return r[ROT_W-1:0];
        end
    endfunction

endpackage

// ----- hw/rtl/quaternion_pose_to_transform.sv -----
`timescale 1ns / 1ps
// Top level: pipelined quaternion pose to 3x4 homogeneous transform.
//
// channel  | dir | contents
// ---------+-----+------------------------------------------------------------
// s_axis   | in  | one pose: quat x, y, z, w (Q2.14), pos x, y, z (Q16.16)
// m_axis   | out | one transform: rot_00..rot_22 (Q2.16), trans x, y, z
//
// One item per cycle sustained while m_axis_tready stays high; stages: products, sums,
// dividend set-up, 18 restoring divide steps, output register.
// The divide steps, one quotient bit each for all nine entries, set the depth.
// Reset clears only the valid bits; payload registers are not reset.
// A stall holds each full stage; empty stages ahead of it still fill.
module quaternion_pose_to_transform (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // quat_x, quat_y, quat_z, quat_w, pos_x, pos_y, pos_z
    input  logic [qpt_pkg::IN_W-1:0] s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21, rot_22,
    // trans_x, trans_y, trans_z, zero pad
    output logic [qpt_pkg::OUT_W-1:0] m_axis_tdata
);
    import qpt_pkg::*;

    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] valid_next;
    logic [NSTG-1:0] ready;

    logic signed [QUAT_W-1:0] qc [4];
    logic signed [PROD_W-1:0] prod_next [NPROD];
    logic signed [PROD_W-1:0] prod_reg  [NPROD];
    logic [3*POS_W-1:0]       pos0_reg;
    logic                     zero0_reg;

    logic signed [SUM_W-1:0]  psum_next [LANES];
    logic signed [SUM_W-1:0]  psum_reg  [LANES];
    logic [NORM_W-1:0]        norm_next;
    logic [NORM_W-1:0]        norm_reg;
    logic [3*POS_W-1:0]       pos1_reg;
    logic                     zero1_reg;

    lane_t                    div_reg   [QUOT_W+1][LANES];
    lane_t                    prep_next [LANES];
    logic [3*POS_W-1:0]       dpos_reg  [QUOT_W+1];
    logic                     dzero_reg [QUOT_W+1];
    logic [NORM_W-1:0]        dnorm_reg [QUOT_W];

    logic [OUT_W-1:0]         out_next;
    logic [OUT_W-1:0]         out_reg;

    // handshake and valid bits
    always_comb
    begin
        ready[NSTG-1] = !valid_reg[NSTG-1] || m_axis_tready;
        for (int i = NSTG - 2; i >= 0; i--)
        begin
            ready[i] = !valid_reg[i] || ready[i+1];
        end
        for (int i = 0; i < NSTG; i++)
        begin
            if (ready[i])
            begin
                valid_next[i] = (i == 0) ? s_axis_tvalid : valid_reg[(i == 0) ? 0 : i - 1];
            end
            else
            begin
                valid_next[i] = valid_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign s_axis_tready = ready[0];
    assign m_axis_tvalid = valid_reg[NSTG-1];
    assign m_axis_tdata  = out_reg;

    // stage 0: component products
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            qc[i] = s_axis_tdata[i*QUAT_W +: QUAT_W];
        end
        prod_next[PR_XX] = qc[0] * qc[0];
        prod_next[PR_YY] = qc[1] * qc[1];
        prod_next[PR_ZZ] = qc[2] * qc[2];
        prod_next[PR_WW] = qc[3] * qc[3];
        prod_next[PR_XY] = qc[0] * qc[1];
        prod_next[PR_XZ] = qc[0] * qc[2];
        prod_next[PR_YZ] = qc[1] * qc[2];
        prod_next[PR_XW] = qc[0] * qc[3];
        prod_next[PR_YW] = qc[1] * qc[3];
        prod_next[PR_ZW] = qc[2] * qc[3];
    end

    always_ff @(posedge clk)
    begin
        if (ready[0])
        begin
            prod_reg  <= prod_next;
            pos0_reg  <= s_axis_tdata[IN_W-1:4*QUAT_W];
            zero0_reg <= (s_axis_tdata[4*QUAT_W-1:0] == '0);
        end
    end

    // stage 1: squared norm and entry sums
    always_comb
    begin
        norm_next = NORM_W'(prod_reg[PR_XX][PROD_W-2:0]) + NORM_W'(prod_reg[PR_YY][PROD_W-2:0])
                  + NORM_W'(prod_reg[PR_ZZ][PROD_W-2:0]) + NORM_W'(prod_reg[PR_WW][PROD_W-2:0]);
        psum_next[0] = SUM_W'(prod_reg[PR_YY]) + SUM_W'(prod_reg[PR_ZZ]);
        psum_next[1] = SUM_W'(prod_reg[PR_XY]) - SUM_W'(prod_reg[PR_ZW]);
        psum_next[2] = SUM_W'(prod_reg[PR_XZ]) + SUM_W'(prod_reg[PR_YW]);
        psum_next[3] = SUM_W'(prod_reg[PR_XY]) + SUM_W'(prod_reg[PR_ZW]);
        psum_next[4] = SUM_W'(prod_reg[PR_XX]) + SUM_W'(prod_reg[PR_ZZ]);
        psum_next[5] = SUM_W'(prod_reg[PR_YZ]) - SUM_W'(prod_reg[PR_XW]);
        psum_next[6] = SUM_W'(prod_reg[PR_XZ]) - SUM_W'(prod_reg[PR_YW]);
        psum_next[7] = SUM_W'(prod_reg[PR_YZ]) + SUM_W'(prod_reg[PR_XW]);
        psum_next[8] = SUM_W'(prod_reg[PR_XX]) + SUM_W'(prod_reg[PR_YY]);
    end

    always_ff @(posedge clk)
    begin
        if (ready[1])
        begin
            psum_reg  <= psum_next;
            norm_reg  <= norm_next;
            pos1_reg  <= pos0_reg;
            zero1_reg <= zero0_reg;
        end
    end

    // stage 2: dividend = |sum| * 2^17 + n/2, split into first remainder and low bits
    always_comb
    begin
        logic [MAG_W-1:0] mag;
        logic [DVD_W-1:0] dvd;
        for (int l = 0; l < LANES; l++)
        begin
            prep_next[l].neg = psum_reg[l][SUM_W-1];
            mag = prep_next[l].neg ? MAG_W'(-psum_reg[l]) : MAG_W'(psum_reg[l]);
            dvd = (DVD_W'(mag) << FRAC_SH) + DVD_W'(norm_reg[NORM_W-1:1]);
            prep_next[l].rem = REM_W'(dvd[DVD_W-1:QUOT_W]);
            prep_next[l].lq  = dvd[QUOT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[2])
        begin
            div_reg[0]   <= prep_next;
            dpos_reg[0]  <= pos1_reg;
            dzero_reg[0] <= zero1_reg;
            dnorm_reg[0] <= norm_reg;
        end
    end

    // restoring divide, one quotient bit per stage for all lanes
    for (genvar j = 1; j <= QUOT_W; j++)
    begin : g_div
        lane_t step_next [LANES];

        always_comb
        begin
            logic [REM_W:0] t;
            logic [REM_W:0] d;
            logic           ge;
            for (int l = 0; l < LANES; l++)
            begin
                t  = {div_reg[j-1][l].rem, div_reg[j-1][l].lq[QUOT_W-1]};
                d  = t - {1'b0, dnorm_reg[j-1]};
                ge = (t >= {1'b0, dnorm_reg[j-1]});
                step_next[l].neg = div_reg[j-1][l].neg;
                step_next[l].rem = ge ? d[REM_W-1:0] : t[REM_W-1:0];
                step_next[l].lq  = {div_reg[j-1][l].lq[QUOT_W-2:0], ge};
            end
        end

        always_ff @(posedge clk)
        begin
            if (ready[2+j])
            begin
                div_reg[j]   <= step_next;
                dpos_reg[j]  <= dpos_reg[j-1];
                dzero_reg[j] <= dzero_reg[j-1];
            end
        end

        if (j < QUOT_W)
        begin : g_norm
            always_ff @(posedge clk)
            begin
                if (ready[2+j])
                begin
                    dnorm_reg[j] <= dnorm_reg[j-1];
                end
            end
        end
    end

    // output stage: sign, diagonal, zero quaternion, saturation, packing
    always_comb
    begin
        logic signed [VAL_W-1:0] qs;
        logic signed [VAL_W-1:0] val;
        out_next = '0;
        for (int l = 0; l < LANES; l++)
        begin
            qs = $signed({1'b0, div_reg[QUOT_W][l].lq});
            if (DIAG_MASK[l])
            begin
                val = dzero_reg[QUOT_W] ? ROT_ONE : ROT_ONE - qs;
            end
            else if (dzero_reg[QUOT_W])
            begin
                val = '0;
            end
            else
            begin
                val = div_reg[QUOT_W][l].neg ? -qs : qs;
            end
            out_next[l*ROT_W +: ROT_W] = sat_rot(val);
        end
        out_next[LANES*ROT_W +: 3*POS_W] = dpos_reg[QUOT_W];
    end

    always_ff @(posedge clk)
    begin
        if (ready[NSTG-1])
        begin
            out_reg <= out_next;
        end
    end

endmodule

// ----- verif/quaternion_pose_to_transform_test.sv -----
`timescale 1ns / 1ps
// Self-checking test of the pose-to-transform block: directed table, random poses, stalls.
module quaternion_pose_to_transform_test;

    import qpt_pkg::*;

    localparam int ONE_Q16    = 65536;
    localparam int PREDICT    = 0;
    localparam int TYPED      = 1;
    localparam int N_DIR      = 19;
    localparam int N_RAND     = 1700;
    localparam int HOLD_LEN   = 200;
    localparam int HOLD_AFTER = 300;
    localparam int DRAIN      = 40;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;

    logic [OUT_W-1:0]  expected_xforms [$];
    logic [OUT_W-1:0]  want;
    int                mismatches = 0;
    int                results_seen = 0;
    bit                steady = 1'b0;
    bit                hold_done = 1'b0;
    int                hold_cycles;

    // qx, qy, qz, qw, px, py, pz, kind, r00, r11, r22 (typed rows: off-diagonal zero)
    int dir_tab [0:N_DIR-1][0:10] = '{
        '{0, 0, 0, 0, 0, 0, 0, TYPED, ONE_Q16, ONE_Q16, ONE_Q16},
        '{0, 0, 0, 0, 32'h7FFFFFFF, 32'h80000000, -1, TYPED, ONE_Q16, ONE_Q16, ONE_Q16},
        '{0, 0, 0, 16384, 32'h80000000, 32'h7FFFFFFF, 0, TYPED, ONE_Q16, ONE_Q16, ONE_Q16},
        '{0, 0, 0, -32768, 1, -1, 65536, TYPED, ONE_Q16, ONE_Q16, ONE_Q16},
        '{16384, 0, 0, 0, 0, 0, 0, TYPED, ONE_Q16, -ONE_Q16, -ONE_Q16},
        '{0, 16384, 0, 0, 5, 6, 7, TYPED, -ONE_Q16, ONE_Q16, -ONE_Q16},
        '{0, 0, -16384, 0, -5, -6, -7, TYPED, -ONE_Q16, -ONE_Q16, ONE_Q16},
        '{-32768, 0, 0, 0, 32'h55555555, 32'hAAAAAAAA, 0, TYPED, ONE_Q16, -ONE_Q16, -ONE_Q16},
        '{1, 0, 0, 0, 0, 0, 0, TYPED, ONE_Q16, -ONE_Q16, -ONE_Q16},
        '{0, 0, 0, 1, 0, 0, 0, TYPED, ONE_Q16, ONE_Q16, ONE_Q16},
        '{32767, 32767, 32767, 32767, 12345678, -12345678, 1, PREDICT, 0, 0, 0},
        '{-32768, -32768, -32768, -32768, 0, 0, 0, PREDICT, 0, 0, 0},
        '{32767, -32768, 32767, -32768, 1, 2, 3, PREDICT, 0, 0, 0},
        '{0, 0, 11585, 11585, 65536, 0, -65536, PREDICT, 0, 0, 0},
        '{-1, -1, -1, -1, 0, 0, 0, PREDICT, 0, 0, 0},
        '{1, 2, 3, 4, 0, 0, 0, PREDICT, 0, 0, 0},
        '{1, 1, 0, 1, 0, 0, 0, PREDICT, 0, 0, 0},
        '{12345, -23456, 3456, -30000, 32'hDEADBEEF, 32'h01234567, 32'h89ABCDEF,
          PREDICT, 0, 0, 0},
        '{-16384, 16384, -16384, 16384, 0, 0, 0, PREDICT, 0, 0, 0}
    };

    quaternion_pose_to_transform dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // round(p * 2^17 / n), ties away from zero, n > 0
    function automatic longint scaled_ratio(input longint p, input longint n);
        longint mag;
        longint q;
        begin
            mag = (p < 0) ? -p : p;
            q = ((mag <<< 17) + (n >>> 1)) / n;
            return (p < 0) ? -q : q;
        end
    endfunction

    function automatic logic [OUT_W-1:0] predict_transform(input logic [IN_W-1:0] pose);
        longint x, y, z, w, n, v;
        longint rv [9];
        logic [OUT_W-1:0] res;
        int i;
        begin
            x = longint'($signed(pose[0*QUAT_W +: QUAT_W]));
            y = longint'($signed(pose[1*QUAT_W +: QUAT_W]));
            z = longint'($signed(pose[2*QUAT_W +: QUAT_W]));
            w = longint'($signed(pose[3*QUAT_W +: QUAT_W]));
            n = x*x + y*y + z*z + w*w;
            if (n == 0)
            begin
                for (i = 0; i < 9; i++)
                begin
                    rv[i] = (i % 4 == 0) ? ONE_Q16 : 0;
                end
            end
            else
            begin
                rv[0] = ONE_Q16 - scaled_ratio(y*y + z*z, n);
                rv[1] = scaled_ratio(x*y - z*w, n);
                rv[2] = scaled_ratio(x*z + y*w, n);
                rv[3] = scaled_ratio(x*y + z*w, n);
                rv[4] = ONE_Q16 - scaled_ratio(x*x + z*z, n);
                rv[5] = scaled_ratio(y*z - x*w, n);
                rv[6] = scaled_ratio(x*z - y*w, n);
                rv[7] = scaled_ratio(y*z + x*w, n);
                rv[8] = ONE_Q16 - scaled_ratio(x*x + y*y, n);
            end
            res = '0;
            for (i = 0; i < 9; i++)
            begin
                v = rv[i];
                if (v > ONE_Q16)
                begin
                    v = ONE_Q16;
                end
                else if (v < -ONE_Q16)
                begin
                    v = -ONE_Q16;
                end
                res[i*ROT_W +: ROT_W] = v[ROT_W-1:0];
            end
            res[LANES*ROT_W +: 3*POS_W] = pose[4*QUAT_W +: 3*POS_W];
            return res;
        end
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        begin
            $display("mismatch at result %0d: %s got %h expected %h",
                     results_seen, field, got, exp_val);
            mismatches++;
        end
    endtask

    // called at a rising edge; returns at the edge where the item is taken
    task automatic send_pose(input logic [IN_W-1:0] pose, input logic [OUT_W-1:0] xform);
        bit taken;
        begin
            while (!steady && $urandom_range(0, 99) < 21)
            begin
                s_axis_tvalid <= 1'b0;
                s_axis_tdata  <= {$urandom, $urandom, $urandom, $urandom, $urandom};
                @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= pose;
            taken = 1'b0;
            while (!taken)
            begin
                @(negedge clk);
                taken = s_axis_tready;
                if (taken)
                begin
                    expected_xforms.push_back(xform);
                end
                @(posedge clk);
            end
        end
    endtask

    // receiver: random stalls, one long hold-off while the sender keeps offering
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                m_axis_tready <= 1'b0;
                hold_cycles = 0;
                while (hold_cycles < HOLD_LEN)
                begin
                    @(posedge clk);
                    hold_cycles++;
                end
                hold_done = 1'b1;
            end
            m_axis_tready <= steady || ($urandom_range(0, 99) >= 21);
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_xforms.size() == 0)
            begin
                report_mismatch("unexpected item", 32'd0, 32'd0);
            end
            else
            begin
                want = expected_xforms.pop_front();
                for (int i = 0; i < LANES; i++)
                begin
                    if (m_axis_tdata[i*ROT_W +: ROT_W] !== want[i*ROT_W +: ROT_W])
                    begin
                        report_mismatch($sformatf("rot_%0d%0d", i / 3, i % 3),
                                        32'(m_axis_tdata[i*ROT_W +: ROT_W]),
                                        32'(want[i*ROT_W +: ROT_W]));
                    end
                end
                for (int k = 0; k < 3; k++)
                begin
                    if (m_axis_tdata[LANES*ROT_W + k*POS_W +: POS_W] !==
                        want[LANES*ROT_W + k*POS_W +: POS_W])
                    begin
                        report_mismatch($sformatf("trans_%0d", k),
                                        m_axis_tdata[LANES*ROT_W + k*POS_W +: POS_W],
                                        want[LANES*ROT_W + k*POS_W +: POS_W]);
                    end
                end
            end
            results_seen++;
        end
    end

    initial
    begin
        logic [IN_W-1:0]  pose;
        logic [OUT_W-1:0] xform;
        logic [15:0]      qv [4];
        int               pick;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < N_DIR; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                pose[c*QUAT_W +: QUAT_W] = dir_tab[r][c][QUAT_W-1:0];
            end
            for (int c = 0; c < 3; c++)
            begin
                pose[4*QUAT_W + c*POS_W +: POS_W] = dir_tab[r][4 + c];
            end
            if (dir_tab[r][7] == TYPED)
            begin
                xform = '0;
                xform[0*ROT_W +: ROT_W] = dir_tab[r][8][ROT_W-1:0];
                xform[4*ROT_W +: ROT_W] = dir_tab[r][9][ROT_W-1:0];
                xform[8*ROT_W +: ROT_W] = dir_tab[r][10][ROT_W-1:0];
                xform[LANES*ROT_W +: 3*POS_W] = pose[4*QUAT_W +: 3*POS_W];
            end
            else
            begin
                xform = predict_transform(pose);
            end
            send_pose(pose, xform);
        end

        for (int i = 0; i < N_RAND; i++)
        begin
            steady = (i >= 1000 && i < 1300);
            pick = $urandom_range(0, 9);
            for (int c = 0; c < 4; c++)
            begin
                case (pick)
                    0: qv[c] = '0;
                    1: qv[c] = 16'($urandom_range(0, 6)) - 16'd3;
                    2: qv[c] = (c == (i % 4)) ? 16'($urandom) : '0;
                    3:
                    begin
                        case ($urandom_range(0, 4))
                            0: qv[c] = 16'h8000;
                            1: qv[c] = 16'hFFFF;
                            2: qv[c] = 16'h0000;
                            3: qv[c] = 16'h0001;
                            default: qv[c] = 16'h7FFF;
                        endcase
                    end
                    default: qv[c] = 16'($urandom);
                endcase
                pose[c*QUAT_W +: QUAT_W] = qv[c];
            end
            pose[4*QUAT_W +: 3*POS_W] = {$urandom, $urandom, $urandom};
            send_pose(pose, predict_transform(pose));
        end
        steady = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (expected_xforms.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN) @(posedge clk);

        if (mismatches == 0 && expected_xforms.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/qpt_pkg.sv
hw/rtl/quaternion_pose_to_transform.sv
verif/quaternion_pose_to_transform_test.sv
